// ===== rtl/core/script_lexer_assert.svh =====
// Assertion macros for the script lexer.
// Used by script_lexer.sv; expects clk and rst_n in the including scope.
`ifndef SCRIPT_LEXER_ASSERT_SVH
`define SCRIPT_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLX_ASSERT_HOLD(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("script_lexer check failed");
`define SLX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("script_lexer check failed");
`else
`define SLX_ASSERT_HOLD(lbl, ante, cons)
`define SLX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/slx_pkg.sv =====
// Shared types and constants for the script lexer.
// Used by slx_lexer, slx_queue and script_lexer; no dependencies.
package slx_pkg;

    localparam int SLX_MAX_PUSH   = 3;
    localparam int SLX_QUEUE_DEPTH = 8;

    localparam logic EV_TEXT = 1'b0;
    localparam logic EV_DONE = 1'b1;

    typedef enum logic [4:0] {
        TOK_IDEN    = 5'd0,
        TOK_IF      = 5'd1,
        TOK_ELSE    = 5'd2,
        TOK_WHILE   = 5'd3,
        TOK_DEF     = 5'd4,
        TOK_RETURN  = 5'd5,
        TOK_LET     = 5'd6,
        TOK_INT     = 5'd7,
        TOK_FLOAT   = 5'd8,
        TOK_STRING  = 5'd9,
        TOK_LBRACE  = 5'd10,
        TOK_RBRACE  = 5'd11,
        TOK_LPAREN  = 5'd12,
        TOK_RPAREN  = 5'd13,
        TOK_GT      = 5'd14,
        TOK_LT      = 5'd15,
        TOK_GE      = 5'd16,
        TOK_LE      = 5'd17,
        TOK_SEMI    = 5'd18,
        TOK_PLUS    = 5'd19,
        TOK_MINUS   = 5'd20,
        TOK_STAR    = 5'd21,
        TOK_DIV     = 5'd22,
        TOK_ASSIGN  = 5'd23,
        TOK_EQEQ    = 5'd24,
        TOK_COMMA   = 5'd25,
        TOK_UNKNOWN = 5'd26,
        TOK_END     = 5'd27
    } token_t;

    typedef struct packed {
        logic       kind;
        token_t     ttype;
        logic [7:0] tbyte;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]                    count;
        result_t [SLX_MAX_PUSH-1:0]    item;
    } push_t;

    // keyword text, first byte in the low bits
    localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
    localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6c65;
    localparam logic [47:0] KW_WHILE  = 48'h0065_6c69_6877;
    localparam logic [47:0] KW_DEF    = 48'h0000_0066_6564;
    localparam logic [47:0] KW_RETURN = 48'h6e72_7574_6572;
    localparam logic [47:0] KW_LET    = 48'h0000_0074_656c;

    function automatic token_t keyword_type(logic [47:0] prefix, logic [2:0] len);
        if (len == 3'd2 && prefix == KW_IF)
            return TOK_IF;
        else if (len == 3'd4 && prefix == KW_ELSE)
            return TOK_ELSE;
        else if (len == 3'd5 && prefix == KW_WHILE)
            return TOK_WHILE;
        else if (len == 3'd3 && prefix == KW_DEF)
            return TOK_DEF;
        else if (len == 3'd6 && prefix == KW_RETURN)
            return TOK_RETURN;
        else if (len == 3'd3 && prefix == KW_LET)
            return TOK_LET;
        else
            return TOK_IDEN;
    endfunction

endpackage

// ===== rtl/core/script_lexer.sv =====
// Top level of the script lexer: input register, lexer core and result queue.
// Depends on slx_pkg, slx_lexer, slx_queue and script_lexer_assert.svh.
//
// Takes one source character per cycle while char_stall is low and emits its
// tokens as a stream of requests: text bytes of identifiers, numbers and
// strings, each followed by a token-complete request that carries the token
// type; the last request caused by a character has last set. A character is
// held in the input register while fewer than three queue entries are free and
// decoded once they are; its results (none to three) go into a QUEUE_DEPTH-entry
// result queue, which drains one request per cycle while token_stall is low. So
// the sustained rate is one character per cycle when each yields at most one
// request and token_stall is low, and is set by the output port (one request
// per cycle) otherwise. end_of_input flushes any open token, emits the end token
// and returns the lexer to its reset state.
`include "script_lexer_assert.svh"
module script_lexer
    import slx_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLX_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] byte_in,
    input  logic       end_of_input,
    output logic       token_valid,
    input  logic       token_stall,
    output logic       event_kind,
    output logic [4:0] token_type,
    output logic [7:0] text_byte,
    output logic       last
);

    logic       char_valid_reg, char_valid_next;
    logic [7:0] char_byte_reg;
    logic       char_eoi_reg;
    logic       room;
    logic       step;
    logic       accept;
    logic       pop;
    push_t      push;
    result_t    head;

    assign step       = char_valid_reg & room;
    assign char_stall = char_valid_reg & ~room;
    assign accept     = char_valid & ~char_stall;
    assign pop        = token_valid & ~token_stall;

    always_comb
    begin
        if (accept)
            char_valid_next = 1'b1;
        else if (step)
            char_valid_next = 1'b0;
        else
            char_valid_next = char_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_valid_reg <= 1'b0;
        else
            char_valid_reg <= char_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_byte_reg <= byte_in;
            char_eoi_reg  <= end_of_input;
        end
    end

    slx_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_byte (char_byte_reg),
        .char_eoi  (char_eoi_reg),
        .push      (push)
    );

    slx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (pop),
        .head_valid (token_valid),
        .head       (head)
    );

    assign event_kind = head.kind;
    assign token_type = head.ttype;
    assign text_byte  = head.tbyte;
    assign last       = head.last;

    `SLX_ASSERT_HOLD(a_push_has_room, push.count != 2'd0, room)
    `SLX_ASSERT_HOLD(a_eoi_emits, step && char_eoi_reg, push.count != 2'd0)
    `SLX_ASSERT_NEXT(a_push_shows, push.count != 2'd0, token_valid)

endmodule

// ===== rtl/core/slx_lexer.sv =====
// Lexer state and per-character decode: turns one character into up to three results.
// Depends on slx_pkg.
module slx_lexer
    import slx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_byte,
    input  logic       char_eoi,
    output push_t      push
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FLOAT,
        MODE_STR,
        MODE_ESC,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR,
        MODE_SLASH,
        MODE_EQ,
        MODE_LT,
        MODE_GT
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [47:0] prefix_reg, prefix_next;
    logic [2:0]  len_reg, len_next;
    logic        prev_reg, prev_next;

    result_t     res [SLX_MAX_PUSH];
    logic [1:0]  n;
    logic        start;
    logic        esc_known;
    logic [7:0]  esc_byte;
    token_t      kw;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic result_t text_res(token_t t, logic [7:0] b);
        return '{kind: EV_TEXT, ttype: t, tbyte: b, last: 1'b0};
    endfunction

    function automatic result_t done_res(token_t t);
        return '{kind: EV_DONE, ttype: t, tbyte: 8'h00, last: 1'b0};
    endfunction

    assign kw = keyword_type(prefix_reg, len_reg);

    always_comb
    begin
        esc_known = 1'b1;
        esc_byte  = 8'h00;
        unique case (char_byte)
            8'h6e:   esc_byte = 8'd10;
            8'h22:   esc_byte = 8'd34;
            8'h61:   esc_byte = 8'd7;
            8'h62:   esc_byte = 8'd8;
            8'h66:   esc_byte = 8'd12;
            8'h72:   esc_byte = 8'd13;
            8'h74:   esc_byte = 8'd9;
            8'h76:   esc_byte = 8'd11;
            8'h5c:   esc_byte = 8'd92;
            8'h30:   esc_byte = 8'd0;
            default: esc_known = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        prev_next   = prev_reg;
        n           = 2'd0;
        start       = 1'b0;
        for (int i = 0; i < SLX_MAX_PUSH; i++)
        begin
            res[i] = done_res(TOK_IDEN);
        end

        if (char_eoi)
        begin
            unique case (mode_reg)
                MODE_IDENT: begin res[n] = done_res(kw); n = n + 2'd1; end
                MODE_INT:   begin res[n] = done_res(TOK_INT); n = n + 2'd1; end
                MODE_FLOAT: begin res[n] = done_res(TOK_FLOAT); n = n + 2'd1; end
                MODE_ESC:
                begin
                    res[n] = text_res(TOK_STRING, 8'h5c); n = n + 2'd1;
                    res[n] = done_res(TOK_STRING); n = n + 2'd1;
                end
                MODE_STR:   begin res[n] = done_res(TOK_STRING); n = n + 2'd1; end
                MODE_SLASH: begin res[n] = done_res(TOK_DIV); n = n + 2'd1; end
                MODE_EQ:    begin res[n] = done_res(TOK_ASSIGN); n = n + 2'd1; end
                MODE_LT:    begin res[n] = done_res(TOK_LT); n = n + 2'd1; end
                MODE_GT:    begin res[n] = done_res(TOK_GT); n = n + 2'd1; end
                default:    ;
            endcase
            res[n]      = done_res(TOK_END);
            n           = n + 2'd1;
            mode_next   = MODE_IDLE;
            prefix_next = '0;
            len_next    = '0;
            prev_next   = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(char_byte) || is_digit(char_byte))
                    begin
                        res[n] = text_res(TOK_IDEN, char_byte); n = n + 2'd1;
                        if (len_reg < 3'd6)
                        begin
                            prefix_next[{len_reg, 3'b000} +: 8] = char_byte;
                            len_next = len_reg + 3'd1;
                        end
                        else
                        begin
                            len_next = 3'd7;
                        end
                    end
                    else
                    begin
                        res[n] = done_res(kw); n = n + 2'd1;
                        prev_next   = (kw == TOK_SEMI);
                        prefix_next = '0;
                        len_next    = '0;
                        start       = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    if (is_digit(char_byte))
                    begin
                        res[n] = text_res(TOK_INT, char_byte); n = n + 2'd1;
                    end
                    else if (char_byte == 8'h2e)
                    begin
                        res[n] = text_res(TOK_FLOAT, char_byte); n = n + 2'd1;
                        mode_next = MODE_FLOAT;
                    end
                    else
                    begin
                        res[n] = done_res(TOK_INT); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                MODE_FLOAT:
                begin
                    if (is_digit(char_byte))
                    begin
                        res[n] = text_res(TOK_FLOAT, char_byte); n = n + 2'd1;
                    end
                    else
                    begin
                        res[n] = done_res(TOK_FLOAT); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (char_byte == 8'h22)
                    begin
                        res[n] = done_res(TOK_STRING); n = n + 2'd1;
                        prev_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                    else if (char_byte == 8'h5c)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res[n] = text_res(TOK_STRING, char_byte); n = n + 2'd1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    if (esc_known)
                    begin
                        res[n] = text_res(TOK_STRING, esc_byte); n = n + 2'd1;
                    end
                    else
                    begin
                        // unknown escape: keep the backslash, then take the byte as text
                        res[n] = text_res(TOK_STRING, 8'h5c); n = n + 2'd1;
                        res[n] = text_res(TOK_STRING, char_byte); n = n + 2'd1;
                    end
                end
                MODE_LINE:
                begin
                    if (char_byte == 8'h0a)
                        mode_next = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (char_byte == 8'h2a)
                        mode_next = MODE_BSTAR;
                end
                MODE_BSTAR:
                begin
                    if (char_byte == 8'h2f)
                        mode_next = MODE_IDLE;
                    else if (char_byte != 8'h2a)
                        mode_next = MODE_BLOCK;
                end
                MODE_SLASH:
                begin
                    if (char_byte == 8'h2f)
                        mode_next = MODE_LINE;
                    else if (char_byte == 8'h2a)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        res[n] = done_res(TOK_DIV); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                MODE_EQ:
                begin
                    if (char_byte == 8'h3d)
                    begin
                        res[n] = done_res(TOK_EQEQ); n = n + 2'd1;
                        prev_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res[n] = done_res(TOK_ASSIGN); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                MODE_LT:
                begin
                    if (char_byte == 8'h3d)
                    begin
                        res[n] = done_res(TOK_LE); n = n + 2'd1;
                        prev_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res[n] = done_res(TOK_LT); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                MODE_GT:
                begin
                    if (char_byte == 8'h3d)
                    begin
                        res[n] = done_res(TOK_GE); n = n + 2'd1;
                        prev_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res[n] = done_res(TOK_GT); n = n + 2'd1;
                        prev_next = 1'b0;
                        start     = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase
        end

        if (start)
        begin
            mode_next = MODE_IDLE;
            if (char_byte == 8'h20 || char_byte == 8'h09 || char_byte == 8'h0d ||
                char_byte == 8'h0a)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_alpha(char_byte))
            begin
                res[n] = text_res(TOK_IDEN, char_byte); n = n + 2'd1;
                prefix_next = {40'd0, char_byte};
                len_next    = 3'd1;
                mode_next   = MODE_IDENT;
            end
            else if (is_digit(char_byte))
            begin
                res[n] = text_res(TOK_INT, char_byte); n = n + 2'd1;
                mode_next = MODE_INT;
            end
            else
            begin
                unique case (char_byte)
                    8'h2f: mode_next = MODE_SLASH;
                    8'h23: mode_next = MODE_LINE;
                    8'h22: mode_next = MODE_STR;
                    8'h3d: mode_next = MODE_EQ;
                    8'h3c: mode_next = MODE_LT;
                    8'h3e: mode_next = MODE_GT;
                    8'h3b:
                    begin
                        // collapse a run of semicolons
                        if (!prev_next)
                        begin
                            res[n] = done_res(TOK_SEMI); n = n + 2'd1;
                            prev_next = 1'b1;
                        end
                    end
                    8'h2b: begin res[n] = done_res(TOK_PLUS); n = n + 2'd1; prev_next = 1'b0; end
                    8'h2d: begin res[n] = done_res(TOK_MINUS); n = n + 2'd1; prev_next = 1'b0; end
                    8'h2a: begin res[n] = done_res(TOK_STAR); n = n + 2'd1; prev_next = 1'b0; end
                    8'h2c: begin res[n] = done_res(TOK_COMMA); n = n + 2'd1; prev_next = 1'b0; end
                    8'h28: begin res[n] = done_res(TOK_LPAREN); n = n + 2'd1; prev_next = 1'b0; end
                    8'h29: begin res[n] = done_res(TOK_RPAREN); n = n + 2'd1; prev_next = 1'b0; end
                    8'h7b: begin res[n] = done_res(TOK_LBRACE); n = n + 2'd1; prev_next = 1'b0; end
                    8'h7d:
                    begin
                        res[n] = done_res(TOK_RBRACE); n = n + 2'd1;
                        res[n] = done_res(TOK_SEMI); n = n + 2'd1;
                        prev_next = 1'b1;
                    end
                    default:
                    begin
                        res[n] = done_res(TOK_UNKNOWN); n = n + 2'd1;
                        prev_next = 1'b0;
                    end
                endcase
            end
        end

        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;
    end

    assign push.count = step ? n : 2'd0;
    assign push.item  = {res[2], res[1], res[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= '0;
            len_reg    <= '0;
            prev_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

// ===== rtl/core/slx_queue.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle on pop.
// Depends on slx_pkg.
module slx_queue
    import slx_pkg::*;
#(
    parameter int DEPTH = SLX_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    input  logic    pop,
    output logic    head_valid,
    output result_t head
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 2;

    result_t             mem_reg [DEPTH];
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] p, logic [1:0] k);
        logic [SUM_W-1:0] s;
        s = {2'b00, p} + SUM_W'(k);
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[ADDR_W-1:0];
    endfunction

    assign room        = count_reg <= CNT_W'(DEPTH - SLX_MAX_PUSH);
    assign head_valid  = count_reg != '0;
    assign head        = mem_reg[rd_ptr_reg];
    assign wr_ptr_next = wrap_add(wr_ptr_reg, push.count);
    assign rd_ptr_next = wrap_add(rd_ptr_reg, {1'b0, pop});
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLX_MAX_PUSH; i++)
        begin
            if (2'(i) < push.count)
                mem_reg[wrap_add(wr_ptr_reg, 2'(i))] <= push.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
